@@ rtl/mks_pkg.sv @@
// Package for the medal key record sorter: record, request, response and queue types,
// capacity constants and the sort key function.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package mks_pkg;

   // Number of records the insertion chain can hold (2 to 64).
   localparam int MAX_RECORDS = 64;
   localparam int COUNT_W     = $clog2(MAX_RECORDS + 1);

   // Depth of the queue between front and back; must be a power of two.
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam int KEY_W       = 38;

   typedef struct packed {
      logic [9:0] gold_count;
      logic [9:0] silver_count;
      logic [9:0] bronze_count;
      logic [7:0] name_initial;
      logic [5:0] record_tag;
      logic       final_item;
   } req_type;

   typedef struct packed {
      logic [9:0] out_gold;
      logic [9:0] out_silver;
      logic [9:0] out_bronze;
      logic [7:0] out_initial;
      logic [5:0] out_tag;
      logic       overflow_seen;
      logic       run_end;
   } rsp_type;

   typedef struct packed {
      logic [9:0] gold;
      logic [9:0] silver;
      logic [9:0] bronze;
      logic [7:0] initial_code;
      logic [5:0] tag;
   } rec_type;

   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      rec_type rec;
      key_type key;
      logic    final_item;
   } qitem_type;

   // Larger key sorts earlier; the initial is inverted so that a smaller code wins.
   function automatic key_type sort_key(input rec_type rec);
      sort_key = {rec.gold, rec.silver, rec.bronze, ~rec.initial_code};
   endfunction

endpackage

@@ rtl/medal_key_record_sorter.sv @@
// Top level of the medal key record sorter: front end, queue and sorting back end.
// Depends on mks_pkg, mks_front, mks_queue and mks_back.
// A run's results follow once its final item has passed the queue and closed the set,
// then one result per cycle for every stored record; rsp_valid has no back pressure.
// Throughput: one item per cycle while loading, set by the insertion chain;
// during a drain of n records up to QDEPTH further items are taken, then busy holds.
// Reset is synchronous and active high; it empties the queue and the store at once.
`timescale 1ns / 1ps

module medal_key_record_sorter
   import mks_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // The front end turns each accepted item into a queue entry that already
   // carries its sort key, so the back end only compares and shifts.
   logic      q_full;
   logic      q_not_empty;
   logic      push;
   logic      pop;
   qitem_type push_item;
   qitem_type head_item;

   mks_front u_front (
      .start     (start),
      .req_data  (req_data),
      .q_full    (q_full),
      .busy      (busy),
      .push      (push),
      .push_item (push_item)
   );

   // The queue lets the front keep taking items while the back end drains a
   // closed set; busy rises only once the queue is full.
   mks_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   // The back end keeps every stored record in order in a chain of cells.
   // An arriving record is placed as it is popped: each cell compares its key
   // with the new one, and the cells behind the insertion point shift by one.
   // A record that arrives when the chain is full is dropped and the overflow
   // flag is set for the whole run. A final item closes the set, and the
   // chain then shifts out toward cell zero, one result per cycle.
   mks_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_item    (head_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/mks_front.sv @@
// Front end of the medal key record sorter: accepts request items and classifies them
// into queue entries carrying the record, its sort key and the final flag. Uses mks_pkg.
`timescale 1ns / 1ps

module mks_front
   import mks_pkg::*;
(
   input  logic      start,
   input  req_type   req_data,
   input  logic      q_full,
   output logic      busy,
   output logic      push,
   output qitem_type push_item
);

   rec_type rec;

   always_comb begin
      rec.gold         = req_data.gold_count;
      rec.silver       = req_data.silver_count;
      rec.bronze       = req_data.bronze_count;
      rec.initial_code = req_data.name_initial;
      rec.tag          = req_data.record_tag;
   end

   assign busy                 = q_full;
   assign push                 = start && !q_full;
   assign push_item.rec        = rec;
   assign push_item.key        = sort_key(rec);
   assign push_item.final_item = req_data.final_item;

endmodule

@@ rtl/mks_queue.sv @@
// Short FIFO between front and back of the medal key record sorter.
// Holds classified items of qitem_type from mks_pkg.
`timescale 1ns / 1ps

module mks_queue
   import mks_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  qitem_type push_item,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output qitem_type head_item
);

   qitem_type            entry_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign full      = (cnt_ff == QCNT_W'(QDEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("queue fill count above depth");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (cnt_ff == $past(cnt_ff) + QCNT_W'(1)))
      else $error("queue count did not follow a push");

   a_pop_advances: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (wr_ptr_ff == $past(wr_ptr_ff)))
      else $error("write pointer moved without a push");

endmodule

@@ rtl/mks_back.sv @@
// Back end of the medal key record sorter: the sorted insertion chain of record cells
// and the drain sequencer that emits a closed set in order. Uses mks_pkg.
`timescale 1ns / 1ps

module mks_back
   import mks_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  qitem_type q_item,
   output logic      pop,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                 state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   rec_type              cell_ff [MAX_RECORDS];
   rec_type              cell_in [MAX_RECORDS];
   logic [MAX_RECORDS-1:0] lt;
   logic                 store_full;

   assign store_full = (count_ff == COUNT_W'(MAX_RECORDS));

   // A cell is "behind" the new record when it is empty or its key is strictly
   // smaller; equal keys stay ahead, which keeps full ties in arrival order.
   always_comb begin
      for (int i = 0; i < MAX_RECORDS; i++) begin
         lt[i] = (COUNT_W'(i) >= count_ff) || (sort_key(cell_ff[i]) < q_item.key);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      for (int i = 0; i < MAX_RECORDS; i++) begin
         cell_in[i] = cell_ff[i];
      end
      unique case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               pop = 1'b1;
               if (store_full) begin
                  ovf_in = 1'b1;
               end else begin
                  if (lt[0]) begin
                     cell_in[0] = q_item.rec;
                  end
                  for (int i = 1; i < MAX_RECORDS; i++) begin
                     if (lt[i-1]) begin
                        cell_in[i] = cell_ff[i-1];
                     end else if (lt[i]) begin
                        cell_in[i] = q_item.rec;
                     end
                  end
                  count_in = count_ff + COUNT_W'(1);
               end
               if (q_item.final_item) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            rsp_valid_in              = 1'b1;
            rsp_data_in.out_gold      = cell_ff[0].gold;
            rsp_data_in.out_silver    = cell_ff[0].silver;
            rsp_data_in.out_bronze    = cell_ff[0].bronze;
            rsp_data_in.out_initial   = cell_ff[0].initial_code;
            rsp_data_in.out_tag       = cell_ff[0].tag;
            rsp_data_in.overflow_seen = ovf_ff;
            rsp_data_in.run_end       = (count_ff == COUNT_W'(1));
            for (int i = 0; i < MAX_RECORDS - 1; i++) begin
               cell_in[i] = cell_ff[i+1];
            end
            count_in = count_ff - COUNT_W'(1);
            if (count_ff == COUNT_W'(1)) begin
               state_in = ST_LOAD;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < MAX_RECORDS; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_RECORDS))
      else $error("stored count above capacity");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (count_ff != '0))
      else $error("drain with an empty store");

   a_run_end_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.run_end) |-> (state_ff == ST_LOAD && count_ff == '0
                                                  && !ovf_ff))
      else $error("run end did not return the store to empty");

   a_result_only_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_DRAIN))
      else $error("result strobe outside a drain");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for medal_key_record_sorter: drives record items and checks
// every sorted result against a behavioral ranking of the stored records.
// Depends on mks_pkg and the medal_key_record_sorter RTL.
`timescale 1ns / 1ps

module testbench;
   import mks_pkg::*;

   // A stall longer than this, with no item taken and no result seen, means a hang.
   localparam int WATCHDOG_LIMIT = 1000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Behavioral copy of the store: records kept in ranked order, plus the drop flag.
   rec_type standings[$];
   bit      standings_dropped = 1'b0;

   // Sorted results that the block still owes, oldest first.
   rsp_type ranked_results[$];

   int  failures     = 0;
   int  quiet_cycles = 0;
   bit  gaps_on      = 1'b1;

   medal_key_record_sorter u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // True when record a must be emitted ahead of record b. Counts rank high first,
   // the initial ranks low first, and a full tie is not "ahead", which keeps the
   // sort stable.
   function automatic bit ranks_ahead(input rec_type a, input rec_type b);
      if (a.gold != b.gold) begin
         return a.gold > b.gold;
      end
      if (a.silver != b.silver) begin
         return a.silver > b.silver;
      end
      if (a.bronze != b.bronze) begin
         return a.bronze > b.bronze;
      end
      return a.initial_code < b.initial_code;
   endfunction

   // Updates the behavioral store for one taken item. A record goes in front of the
   // first stored record it ranks ahead of, so equal keys stay in arrival order.
   // When the store is full the record is dropped, even a final one. A final item
   // then releases the whole ranked list as expected results and empties the store.
   task automatic place_record(input req_type item);
      rec_type rec;
      rsp_type want;
      int      slot;
      rec.gold         = item.gold_count;
      rec.silver       = item.silver_count;
      rec.bronze       = item.bronze_count;
      rec.initial_code = item.name_initial;
      rec.tag          = item.record_tag;
      if (standings.size() >= MAX_RECORDS) begin
         standings_dropped = 1'b1;
      end else begin
         slot = standings.size();
         for (int i = 0; i < standings.size(); i++) begin
            if (ranks_ahead(rec, standings[i])) begin
               slot = i;
               break;
            end
         end
         standings.insert(slot, rec);
      end
      if (item.final_item) begin
         for (int i = 0; i < standings.size(); i++) begin
            want.out_gold      = standings[i].gold;
            want.out_silver    = standings[i].silver;
            want.out_bronze    = standings[i].bronze;
            want.out_initial   = standings[i].initial_code;
            want.out_tag       = standings[i].tag;
            want.overflow_seen = standings_dropped;
            want.run_end       = (i == standings.size() - 1);
            ranked_results.push_back(want);
         end
         standings.delete();
         standings_dropped = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      failures++;
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   task automatic compare_field(input string what, input int got, input int want);
      if (got != want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // Sends one item. Inputs change only at the falling edge; the item counts as taken
   // at the first rising edge that sees start high and busy low. While gaps are on,
   // the sender sometimes drops start for a random burst before the item.
   task automatic send_record(input req_type item);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      start    = 1'b1;
      req_data = item;
      do begin
         @(posedge clock);
      end while (busy);
      place_record(item);
      @(negedge clock);
   endtask

   // Lowers start once the last item of a test has been taken.
   task automatic quiet_sender();
      start = 1'b0;
   endtask

   // Holds the sender off until every owed result has come out.
   task automatic wait_for_results();
      start = 1'b0;
      while (ranked_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   function automatic req_type make_record(input int gold, input int silver,
                                           input int bronze, input int initial_code,
                                           input int tag, input bit last);
      req_type item;
      item.gold_count   = gold[9:0];
      item.silver_count = silver[9:0];
      item.bronze_count = bronze[9:0];
      item.name_initial = initial_code[7:0];
      item.record_tag   = tag[5:0];
      item.final_item   = last;
      return item;
   endfunction

   // Narrow records draw from a handful of values so that ties on every key are
   // common; wide records use the full range of each field.
   function automatic req_type random_record(input bit narrow, input bit last);
      req_type item;
      item.gold_count   = narrow ? 10'($urandom_range(0, 2)) : 10'($urandom);
      item.silver_count = narrow ? 10'($urandom_range(1021, 1023)) : 10'($urandom);
      item.bronze_count = narrow ? 10'($urandom_range(0, 1)) : 10'($urandom);
      item.name_initial = narrow ? 8'($urandom_range(65, 67)) : 8'($urandom);
      item.record_tag   = 6'($urandom);
      item.final_item   = last;
      return item;
   endfunction

   // Runs of one record each: all fields at their top, all at zero, and two
   // alternating bit patterns, so every field bit is seen at both values.
   task automatic test_single_records();
      send_record(make_record(1023, 1023, 1023, 255, 63, 1'b1));
      send_record(make_record(0, 0, 0, 0, 0, 1'b1));
      send_record(make_record('h2AA, 'h155, 'h2AA, 'hAA, 'h15, 1'b1));
      send_record(make_record('h155, 'h2AA, 'h155, 'h55, 'h2A, 1'b1));
      quiet_sender();
   endtask

   // One set that walks the key order: gold decides first, then silver, then bronze,
   // then the smaller initial. Three records tie on every key and must come out in
   // the order they went in.
   task automatic test_key_priority();
      send_record(make_record(5, 0, 0, 90, 1, 1'b0));
      send_record(make_record(7, 0, 0, 90, 2, 1'b0));
      send_record(make_record(7, 3, 0, 90, 3, 1'b0));
      send_record(make_record(7, 3, 9, 90, 4, 1'b0));
      send_record(make_record(7, 3, 9, 65, 5, 1'b0));
      send_record(make_record(7, 3, 9, 65, 6, 1'b0));
      send_record(make_record(7, 3, 9, 65, 7, 1'b0));
      send_record(make_record(0, 1023, 1023, 0, 8, 1'b0));
      send_record(make_record(1023, 0, 0, 255, 9, 1'b0));
      send_record(make_record(7, 3, 9, 66, 10, 1'b1));
      quiet_sender();
   endtask

   // Fills the store to exactly its capacity; the final record still fits, so the
   // run carries no overflow mark.
   task automatic test_full_store();
      for (int i = 0; i < MAX_RECORDS; i++) begin
         send_record(random_record(1'b1, i == MAX_RECORDS - 1));
      end
      quiet_sender();
   endtask

   // Overfills the store: two plain records and then the final record are dropped.
   // The full run must still come out, marked as overflowed. The sender then waits
   // for the whole run before a short set that must show the mark cleared again.
   task automatic test_overflow();
      for (int i = 0; i < MAX_RECORDS + 2; i++) begin
         send_record(random_record(i % 2 == 0, 1'b0));
      end
      send_record(random_record(1'b0, 1'b1));
      wait_for_results();
      for (int i = 0; i < 3; i++) begin
         send_record(random_record(1'b1, i == 2));
      end
      quiet_sender();
   endtask

   // Random sets of records. Most sets are short; now and then one is long enough to
   // reach or pass the capacity. Some sets wait for their run to drain before the
   // next one starts, the rest overlap the next set's loading with the drain. The
   // last stretch runs with no gaps from the sender.
   task automatic test_random_sets();
      int  sent;
      int  set_size;
      int  set_index;
      bit  narrow;
      sent      = 0;
      set_index = 0;
      while (sent < 220) begin
         if ($urandom_range(0, 9) == 0) begin
            set_size = $urandom_range(40, 70);
         end else begin
            set_size = $urandom_range(1, 10);
         end
         narrow = 1'($urandom_range(0, 1));
         if (sent > 180) begin
            gaps_on = 1'b0;
         end
         for (int i = 0; i < set_size; i++) begin
            send_record(random_record(narrow, i == set_size - 1));
            sent++;
         end
         if (set_index % 7 == 3) begin
            wait_for_results();
         end
         set_index++;
      end
      quiet_sender();
   endtask

   // Every result is checked at the rising edge that ends its strobe cycle, against
   // the oldest result still owed.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (ranked_results.size() == 0) begin
            report_mismatch("result with none expected, tag", int'(rsp_data.out_tag), 0);
         end else begin
            want = ranked_results.pop_front();
            compare_field("out_gold", int'(rsp_data.out_gold), int'(want.out_gold));
            compare_field("out_silver", int'(rsp_data.out_silver), int'(want.out_silver));
            compare_field("out_bronze", int'(rsp_data.out_bronze), int'(want.out_bronze));
            compare_field("out_initial", int'(rsp_data.out_initial),
                          int'(want.out_initial));
            compare_field("out_tag", int'(rsp_data.out_tag), int'(want.out_tag));
            compare_field("overflow_seen", int'(rsp_data.overflow_seen),
                          int'(want.overflow_seen));
            compare_field("run_end", int'(rsp_data.run_end), int'(want.run_end));
         end
      end
   end

   // Any cycle that takes an item or shows a result restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Reset is held high from the start and released at a falling edge; the tests then
   // run in turn. At the end the bench waits for the last owed result and a few
   // more cycles, so a stray extra result is still caught.
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_single_records();
      test_key_priority();
      test_full_store();
      test_overflow();
      test_random_sets();
      while (ranked_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
